FILE: sv/uuencode_line_encoder_core_macros.svh
// Assertion macros for the uuencode line encoder.
// Depends on nothing; included by the top level, which supplies clk and rst_n.
`ifndef UUENCODE_LINE_ENCODER_CORE_MACROS_SVH
`define UUENCODE_LINE_ENCODER_CORE_MACROS_SVH

// Property checked only while reset is released.
`define UULE_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define UULE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/uule_pkg.sv
// Shared constants, types and the character mapping of the uuencode line encoder.
// Depends on nothing.
package uule_pkg;

    localparam int LINE_BYTES_DEF = 45;
    localparam int LINE_BYTES_MAX = 45;
    localparam int CNT_W = $clog2(LINE_BYTES_MAX + 1);

    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_BQ   = 8'h60;
    localparam logic [7:0] CHAR_BIAS = 8'h20;

    typedef struct packed {
        logic             line_en;
        logic             end_en;
        logic             bank;
        logic [CNT_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    function automatic logic [7:0] enc6(input logic [5:0] v);
        logic [7:0] r;
        if (v == 6'd0)
        begin
            r = CHAR_BQ;
        end
        else
        begin
            r = {2'b00, v} + CHAR_BIAS;
        end
        return r;
    endfunction

endpackage

FILE: sv/uule_front.sv
// Input side: collects bytes into one of two line banks and issues line and end-of-data commands.
// Depends on uule_pkg.
module uule_front #(
    parameter int LINE_BYTES = uule_pkg::LINE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     data_byte,
    input  logic           byte_valid,
    input  logic           end_of_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           cmd_full,
    output logic           cmd_push,
    output uule_pkg::cmd_t cmd,
    output uule_pkg::wr_t  wr,
    input  uule_pkg::rel_t rel
);

    logic [uule_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       wbank_reg, wbank_next;
    logic [1:0]                 busy_reg, busy_next;
    logic [uule_pkg::CNT_W-1:0] n1;
    logic                       accept;
    logic                       full;
    logic                       line_en;

    always_comb
    begin
        in_ready = !cmd_full && !busy_reg[wbank_reg];
        accept   = in_valid && in_ready;
        n1       = byte_valid ? count_reg + uule_pkg::CNT_W'(1) : count_reg;
        full     = byte_valid && (n1 == uule_pkg::CNT_W'(LINE_BYTES));
        line_en  = full || (end_of_data && (n1 != '0));

        wr.en   = accept && byte_valid;
        wr.bank = wbank_reg;
        wr.addr = count_reg;
        wr.data = data_byte;

        cmd.line_en = line_en;
        cmd.end_en  = end_of_data;
        cmd.bank    = wbank_reg;
        cmd.len     = n1;
        cmd_push    = accept && (line_en || end_of_data);

        busy_next  = busy_reg;
        wbank_next = wbank_reg;
        count_next = count_reg;
        if (rel.en)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            count_next = line_en ? '0 : n1;
            if (line_en)
            begin
                busy_next[wbank_reg] = 1'b1;
                wbank_next           = !wbank_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

FILE: sv/uule_cmd_fifo.sv
// Two-entry command queue between the input side and the character sequencer.
// Depends on uule_pkg.
module uule_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uule_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           pop_valid,
    input  logic           pop_ready,
    output uule_pkg::cmd_t pop_cmd
);

    uule_pkg::cmd_t entry_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           do_pop;

    always_comb
    begin
        full      = (fill_reg == 2'd2);
        pop_valid = (fill_reg != 2'd0);
        pop_cmd   = entry_reg[rptr_reg];
        do_pop    = pop_valid && pop_ready;
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = do_pop ? !rptr_reg : rptr_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/uule_back.sv
// Output side: holds the two line banks and turns each command into characters.
// Depends on uule_pkg.
module uule_back #(
    parameter int LINE_BYTES = uule_pkg::LINE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  uule_pkg::wr_t  wr,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  uule_pkg::cmd_t cmd,
    output uule_pkg::rel_t rel,
    output logic [7:0]     out_char,
    output logic           last_of_run,
    output logic           out_valid,
    input  logic           out_ready
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int BW = uule_pkg::CNT_W + 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LEN  = 6'b000010,
        ST_GRP  = 6'b000100,
        ST_NL   = 6'b001000,
        ST_EQ   = 6'b010000,
        ST_ENL  = 6'b100000
    } state_t;

    logic [7:0] mem [2][LINE_BYTES];

    state_t                     state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_char_reg, out_char_next;
    logic                       last_reg, last_next;
    logic                       end_en_reg, end_en_next;
    logic                       bank_reg, bank_next;
    logic [uule_pkg::CNT_W-1:0] len_reg, len_next;
    logic [BW-1:0]              baddr_reg, baddr_next;
    logic [BW-1:0]              gbase_reg, gbase_next;
    logic [1:0]                 ci_reg, ci_next;
    logic [7:0]                 prev_reg, prev_next;
    logic [7:0]                 rd_data_reg;
    logic                       rd_pad_reg, rd_pad_next;
    logic                       rd_en;
    logic                       issue;
    logic                       can_emit;
    logic [7:0]                 eff;
    logic [BW-1:0]              gsum;

    always_comb
    begin
        can_emit  = !out_valid_reg || out_ready;
        cmd_ready = (state_reg == ST_IDLE);
        eff       = rd_pad_reg ? 8'h00 : rd_data_reg;
        gsum      = gbase_reg + BW'(3);

        state_next     = state_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        end_en_next    = end_en_reg;
        bank_next      = bank_reg;
        len_next       = len_reg;
        baddr_next     = baddr_reg;
        gbase_next     = gbase_reg;
        ci_next        = ci_reg;
        prev_next      = prev_reg;
        issue          = 1'b0;
        rel.en         = 1'b0;
        rel.bank       = bank_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    end_en_next = cmd.end_en;
                    bank_next   = cmd.bank;
                    len_next    = cmd.len;
                    baddr_next  = '0;
                    gbase_next  = '0;
                    ci_next     = 2'd0;
                    state_next  = cmd.line_en ? ST_LEN : ST_EQ;
                end
            end
            ST_LEN:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = uule_pkg::enc6(len_reg);
                    last_next      = 1'b0;
                    issue          = 1'b1;
                    state_next     = ST_GRP;
                end
            end
            ST_GRP:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    case (ci_reg)
                        2'd0:
                        begin
                            out_char_next = uule_pkg::enc6(eff[7:2]);
                            prev_next     = eff;
                            issue         = 1'b1;
                        end
                        2'd1:
                        begin
                            out_char_next = uule_pkg::enc6({prev_reg[1:0], eff[7:4]});
                            prev_next     = eff;
                            issue         = 1'b1;
                        end
                        2'd2:
                        begin
                            out_char_next = uule_pkg::enc6({prev_reg[3:0], eff[7:6]});
                            prev_next     = eff;
                            issue         = 1'b1;
                        end
                        default:
                        begin
                            out_char_next = uule_pkg::enc6(prev_reg[5:0]);
                            gbase_next    = gsum;
                            if (gsum >= {1'b0, len_reg})
                            begin
                                state_next = ST_NL;
                            end
                        end
                    endcase
                    ci_next = ci_reg + 2'd1;
                end
            end
            ST_NL:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = uule_pkg::CHAR_NL;
                    last_next      = !end_en_reg;
                    rel.en         = 1'b1;
                    state_next     = end_en_reg ? ST_EQ : ST_IDLE;
                end
            end
            ST_EQ:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = uule_pkg::CHAR_BQ;
                    last_next      = 1'b0;
                    state_next     = ST_ENL;
                end
            end
            ST_ENL:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = uule_pkg::CHAR_NL;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_en       = issue && (baddr_reg < {1'b0, len_reg});
        rd_pad_next = issue ? !(baddr_reg < {1'b0, len_reg}) : rd_pad_reg;
        if (issue)
        begin
            baddr_next = baddr_reg + BW'(1);
        end

        out_char    = out_char_reg;
        last_of_run = last_reg;
        out_valid   = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        end_en_reg   <= end_en_next;
        bank_reg     <= bank_next;
        len_reg      <= len_next;
        baddr_reg    <= baddr_next;
        gbase_reg    <= gbase_next;
        ci_reg       <= ci_next;
        prev_reg     <= prev_next;
        rd_pad_reg   <= rd_pad_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.bank][wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[bank_reg][baddr_reg[AW-1:0]];
        end
    end

endmodule

FILE: sv/uuencode_line_encoder_core.sv
// Top level of the uuencode line encoder: input side, command queue, output side.
// Depends on uule_pkg, uule_front, uule_cmd_fifo, uule_back and the macro header.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------------
//   in      | in_valid / in_ready | data_byte, byte_valid, end_of_data
//   out     | out_valid/out_ready | out_char, last_of_run
//
// An item is taken on each in_valid/in_ready handshake; bytes go into one of two line banks.
// The output sequencer emits its characters through a single character register,
// which holds while out_ready is low; the empty closing line follows the last
// line, or stands alone when no bytes are held.
// The input stalls while both banks hold lines or the command queue is full.
// Reset clears the byte count, bank flags, queue and sequencer; no clearing pass.
`include "uuencode_line_encoder_core_macros.svh"

module uuencode_line_encoder_core #(
    parameter int LINE_BYTES = uule_pkg::LINE_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       end_of_data,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] out_char,
    output logic       last_of_run,
    output logic       out_valid,
    input  logic       out_ready
);

    logic           cmd_full;
    logic           cmd_push;
    uule_pkg::cmd_t push_cmd;
    logic           cmd_valid;
    logic           cmd_ready;
    uule_pkg::cmd_t pop_cmd;
    uule_pkg::wr_t  wr;
    uule_pkg::rel_t rel;

    uule_front #(
        .LINE_BYTES(LINE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .end_of_data(end_of_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd),
        .wr         (wr),
        .rel        (rel)
    );

    uule_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (cmd_full),
        .pop_valid(cmd_valid),
        .pop_ready(cmd_ready),
        .pop_cmd  (pop_cmd)
    );

    uule_back #(
        .LINE_BYTES(LINE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (pop_cmd),
        .rel        (rel),
        .out_char   (out_char),
        .last_of_run(last_of_run),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    `UULE_ASSERT_RUN(a_last_is_newline, (out_valid && last_of_run) |-> (out_char == uule_pkg::CHAR_NL), "last item of a run is not a newline")
    `UULE_ASSERT_RUN(a_char_printable, out_valid |-> ((out_char == uule_pkg::CHAR_NL) || ((out_char >= 8'h21) && (out_char <= 8'h60))), "encoded character out of range")
    `UULE_ASSERT_ALWAYS(a_no_push_when_full, cmd_push |-> !cmd_full, "command pushed into a full queue")

endmodule
